@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante must be followed in the same cycle by cons
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// cond must never hold
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: forbidden condition");

`endif

@@ rtl/core/mmtq_pkg.sv @@
// ----------------------------------------------------------------------------
// mmtq_pkg
// Types and constants for the MIDI message transmit queue.
// ----------------------------------------------------------------------------
package mmtq_pkg;

   typedef enum logic [2:0] {
      OP_NOTE_ON  = 3'd0,
      OP_NOTE_OFF = 3'd1,
      OP_CTRL     = 3'd2,
      OP_ALL_OFF  = 3'd3,
      OP_POP      = 3'd4
   } mmtq_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WB1,
      ST_WB2,
      ST_RDWAIT
   } mmtq_state_type;

   localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
   localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
   localparam logic [7:0] STATUS_CTRL     = 8'hB0;
   localparam logic [7:0] DATA_MASK       = 8'h7F;
   localparam logic [7:0] CC_ALL_OFF      = 8'd123;
   localparam int         CHAN_W          = 4;
   localparam int         COUNT_OUT_W     = 9;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] data_first;
      logic [7:0] data_second;
   } mmtq_req_type;

   typedef struct packed {
      logic                   byte_valid;
      logic [7:0]             byte_out;
      logic                   message_dropped;
      logic                   overflow_seen;
      logic [COUNT_OUT_W-1:0] bytes_pending;
   } mmtq_rsp_type;

   typedef struct packed {
      logic       wr_en;
      logic       rd_en;
      logic [7:0] wr_data;
   } mmtq_mem_cmd_type;

endpackage

@@ rtl/core/mmtq_store.sv @@
// ----------------------------------------------------------------------------
// mmtq_store
// Single-port byte memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module mmtq_store #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  logic                        clock,
   input  mmtq_pkg::mmtq_mem_cmd_type  mem_cmd,
   input  logic [ADDR_W-1:0]           mem_addr,
   output logic [7:0]                  rd_data
);
   import mmtq_pkg::*;

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem[mem_addr] <= mem_cmd.wr_data;
      end
      if (mem_cmd.rd_en) begin
         rd_data <= mem[mem_addr];
      end
   end

endmodule

@@ rtl/core/mmtq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mmtq_ctrl
// Request sequencer: ring pointers, overflow flag, memory access steps.
// ----------------------------------------------------------------------------
module mmtq_ctrl #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  mmtq_pkg::mmtq_req_type       req_data,
   input  logic [mmtq_pkg::CHAN_W-1:0]  channel,
   output logic                         busy,
   output logic                         done,
   output mmtq_pkg::mmtq_rsp_type       rsp_next,
   output mmtq_pkg::mmtq_mem_cmd_type   mem_cmd,
   output logic [ADDR_W-1:0]            mem_addr,
   input  logic [7:0]                   rd_data
);
   import mmtq_pkg::*;

   localparam int CNT_W = ADDR_W + 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]  DEPTH_C   = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0]  MSG_LEN   = CNT_W'(3);

   mmtq_state_type     state_ff, state_in;
   logic [ADDR_W-1:0]  wp_ff, wp_in;
   logic [ADDR_W-1:0]  rp_ff, rp_in;
   logic               ovf_ff, ovf_in;
   mmtq_req_type       req_ff;

   logic               accept;
   logic               is_enq, is_pop, fits, nonempty;
   logic [CNT_W-1:0]   pend_cur, pend_next;
   logic [CNT_W+8:0]   pend_ext;
   logic [7:0]         byte0, byte1, byte2;

   function automatic logic [CNT_W-1:0] count_of(input logic [ADDR_W-1:0] w,
                                                 input logic [ADDR_W-1:0] r);
      logic [CNT_W-1:0] c;
      if (w >= r) begin
         c = {1'b0, w} - {1'b0, r};
      end else begin
         c = {1'b0, w} + DEPTH_C - {1'b0, r};
      end
      return c;
   endfunction

   function automatic logic [ADDR_W-1:0] bump(input logic [ADDR_W-1:0] p);
      return (p == LAST_ADDR) ? '0 : p + ADDR_W'(1);
   endfunction

   assign is_enq   = req_ff.req_type inside {OP_NOTE_ON, OP_NOTE_OFF, OP_CTRL, OP_ALL_OFF};
   assign is_pop   = (req_ff.req_type == OP_POP);
   assign pend_cur = count_of(wp_ff, rp_ff);
   assign fits     = (pend_cur + MSG_LEN) < DEPTH_C;
   assign nonempty = (wp_ff != rp_ff);

   assign done = ((state_ff == ST_EXEC) && !(is_enq && fits) && !(is_pop && nonempty)) ||
                 (state_ff == ST_WB2) || (state_ff == ST_RDWAIT);
   assign busy   = !((state_ff == ST_IDLE) || done);
   assign accept = start && !busy;

   // message bytes
   always_comb begin
      case (req_ff.req_type)
         OP_NOTE_ON:  byte0 = STATUS_NOTE_ON  | {4'h0, channel};
         OP_NOTE_OFF: byte0 = STATUS_NOTE_OFF | {4'h0, channel};
         default:     byte0 = STATUS_CTRL     | {4'h0, channel};
      endcase
      byte1 = (req_ff.req_type == OP_ALL_OFF) ? CC_ALL_OFF : (req_ff.data_first & DATA_MASK);
      byte2 = (req_ff.req_type inside {OP_NOTE_OFF, OP_ALL_OFF}) ?
              8'h00 : (req_ff.data_second & DATA_MASK);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (is_enq && fits) begin
               state_in = ST_WB1;
            end else if (is_pop && nonempty) begin
               state_in = ST_RDWAIT;
            end else begin
               state_in = accept ? ST_EXEC : ST_IDLE;
            end
         end
         ST_WB1: begin
            state_in = ST_WB2;
         end
         ST_WB2, ST_RDWAIT: begin
            state_in = accept ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and memory commands
   always_comb begin
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      ovf_in   = ovf_ff;
      mem_cmd  = '0;
      mem_addr = wp_ff;
      rsp_next = '0;
      case (state_ff)
         ST_EXEC: begin
            if (is_enq) begin
               if (fits) begin
                  mem_cmd.wr_en   = 1'b1;
                  mem_cmd.wr_data = byte0;
                  wp_in           = bump(wp_ff);
               end else begin
                  ovf_in                   = 1'b1;
                  rsp_next.message_dropped = 1'b1;
               end
            end else if (is_pop && nonempty) begin
               mem_cmd.rd_en = 1'b1;
               mem_addr      = rp_ff;
               rp_in         = bump(rp_ff);
            end
         end
         ST_WB1: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_data = byte1;
            wp_in           = bump(wp_ff);
         end
         ST_WB2: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_data = byte2;
            wp_in           = bump(wp_ff);
         end
         ST_RDWAIT: begin
            rsp_next.byte_valid = 1'b1;
            rsp_next.byte_out   = rd_data;
         end
         default: begin
         end
      endcase
      rsp_next.overflow_seen = ovf_in;
      rsp_next.bytes_pending = pend_ext[COUNT_OUT_W-1:0];
   end

   assign pend_next = count_of(wp_in, rp_in);
   assign pend_ext  = {9'd0, pend_next};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wp_ff    <= '0;
         rp_ff    <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

endmodule

@@ rtl/core/midi_message_tx_queue.sv @@
// ----------------------------------------------------------------------------
// midi_message_tx_queue
// Builds three-byte MIDI channel messages and queues their bytes for transmit.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a request transfers when start is high and busy is low.
//   Types 0..3 build a note on, note off, control change or all notes off
//   message and queue its three bytes whole, or drop it whole when fewer than
//   three entries are free (sticky overflow flag). Type 4 pops one byte.
//   Response channel: one result per request, shown for one cycle with
//   rsp_strobe high. The receiver cannot stall; every result is taken.
//   Steps: a queued message passes through EXEC, WB1 and WB2, a pop that
//   returns a byte through EXEC and RDWAIT, a drop, an empty pop or an
//   unused code through EXEC alone; the response is registered from the
//   last of these. A new request may transfer in the last working cycle of
//   the previous one. The steps follow from the single-port byte memory:
//   one write per message byte, one read and then registered read data per pop.
//   CSR channel: writes the 4-bit MIDI channel; accepted while not busy.
//   Reset (synchronous) empties the queue, clears the overflow flag and the
//   channel register. Memory contents are not cleared; no clearing pass.
// ----------------------------------------------------------------------------
module midi_message_tx_queue #(
   parameter int FIFO_DEPTH = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  mmtq_pkg::mmtq_req_type       req_data,
   output logic                         rsp_strobe,
   output mmtq_pkg::mmtq_rsp_type       rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [mmtq_pkg::CHAN_W-1:0]  csr_data
);
   import mmtq_pkg::*;

   `include "assert_macros.svh"

   localparam int ADDR_W = $clog2(FIFO_DEPTH);

   logic [CHAN_W-1:0]  channel_ff;
   logic               rsp_strobe_ff;
   mmtq_rsp_type       rsp_data_ff;
   logic               done;
   mmtq_rsp_type       rsp_next;
   mmtq_mem_cmd_type   mem_cmd;
   logic [ADDR_W-1:0]  mem_addr;
   logic [7:0]         rd_data;

   assign csr_ready = !busy;

   mmtq_ctrl #(
      .DEPTH  (FIFO_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .channel  (channel_ff),
      .busy     (busy),
      .done     (done),
      .rsp_next (rsp_next),
      .mem_cmd  (mem_cmd),
      .mem_addr (mem_addr),
      .rd_data  (rd_data)
   );

   mmtq_store #(
      .DEPTH  (FIFO_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock    (clock),
      .mem_cmd  (mem_cmd),
      .mem_addr (mem_addr),
      .rd_data  (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) channel_ff <= csr_data;
         rsp_strobe_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `ASSERT_IMPLIES(a_drop_sets_flag, clock, reset,
                   rsp_strobe && rsp_data.message_dropped, rsp_data.overflow_seen)
   `ASSERT_IMPLIES(a_empty_byte_zero, clock, reset,
                   rsp_strobe && !rsp_data.byte_valid, rsp_data.byte_out == 8'h00)
   `ASSERT_NEVER(a_pop_not_drop, clock, reset,
                 rsp_strobe && rsp_data.byte_valid && rsp_data.message_dropped)
   `ASSERT_NEVER(a_mem_one_access, clock, reset, mem_cmd.wr_en && mem_cmd.rd_en)

endmodule
